@@ rtl/core/sats_pkg.sv @@
`default_nettype none

package sats_pkg;

  // Configuration register layout.
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned ColumnsW    = 11;
  localparam int unsigned RowsW       = 16;
  localparam int unsigned ElemW       = 32;
  localparam int unsigned MaxColumnsDefault = 1024;

  localparam logic [ColumnsW-1:0] ColumnsReset = ColumnsW'(1024);
  localparam logic [RowsW-1:0]    RowsReset    = RowsW'(1);

  // Register index codes, taken from paddr[2].
  typedef enum logic {
    RegColumns = 1'b0,
    RegRows    = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

@@ rtl/core/summed_area_table_stream_unit.sv @@
// Summed-area table (integral image) over a stream of signed 32-bit matrix
// elements in row-major order. Each accepted element on the slave stream gives
// one transaction on the master stream carrying the wrapped 2D inclusive
// prefix sum at that position. m_axis_tuser_o flags the last column of a row
// and m_axis_tlast_o the last element of a frame.
// Frame size is set through the APB port: columns at address 0, rows at 4.
// Write them only while no element is in flight.
// The line memory that holds the previous row's sums is read at the accepting
// edge into the read stage (s1), and the sum then enters the output register
// (s2). Throughput is one element per cycle while m_axis_tready_i is not held
// low, set by the single read port and the single write port of that memory;
// a sum written at the same edge as a read of the same entry is forwarded.
// Reset clears the position counters and the row sum and sets columns = 1024,
// rows = 1; the line memory is not cleared since the first row of every frame
// ignores what it reads there. When the receiver holds m_axis_tready_i low,
// the output register and the read stage hold, and s_axis_tready_o drops once
// both are full, so no transaction is lost.
`default_nettype none

module summed_area_table_stream_unit #(
  parameter int unsigned MAX_COLUMNS = sats_pkg::MaxColumnsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // APB configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sats_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [sats_pkg::CfgDataW-1:0]  pwdata,
  output logic      [sats_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready,
  // Input stream.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [sats_pkg::ElemW-1:0]     s_axis_tdata_i,  // [31:0] element
  // Output stream.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic      [sats_pkg::ElemW-1:0]     m_axis_tdata_o,  // [31:0] prefix_sum
  output logic                                m_axis_tuser_o,  // [0] row_end
  output logic                                m_axis_tlast_o   // frame_end
);

  localparam int unsigned ColW = $clog2(MAX_COLUMNS);
  localparam int unsigned CntW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CmpW = (CntW > sats_pkg::ColumnsW) ? CntW + 1
                                                            : sats_pkg::ColumnsW + 1;
  localparam int unsigned RowW = sats_pkg::RowsW;
  localparam int unsigned DW   = sats_pkg::ElemW;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [sats_pkg::ColumnsW-1:0] columns_q;
  logic [RowW-1:0]               rows_q;
  logic                          cfg_wr;
  sats_pkg::reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = sats_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= sats_pkg::ColumnsReset;
      rows_q    <= sats_pkg::RowsReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sats_pkg::RegColumns: columns_q <= pwdata[sats_pkg::ColumnsW-1:0];
        sats_pkg::RegRows:    rows_q    <= pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      sats_pkg::RegColumns: prdata = sats_pkg::CfgDataW'(columns_q);
      sats_pkg::RegRows:    prdata = sats_pkg::CfgDataW'(rows_q);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective frame size.
  logic [CmpW-1:0] cols_raw, cols_eff;
  logic [RowW:0]   rows_eff;

  always_comb begin
    cols_raw = CmpW'(columns_q);
    if (cols_raw == '0) cols_raw = CmpW'(1);
    cols_eff = (cols_raw > CmpW'(MAX_COLUMNS)) ? CmpW'(MAX_COLUMNS) : cols_raw;
    rows_eff = (rows_q == '0) ? (RowW+1)'(1) : {1'b0, rows_q};
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: read stage (s1) and output register (s2).
  logic s1_valid_q, s2_valid_q;
  logic adv, s_acc;

  assign adv             = !s2_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Position counters and row running sum, updated at input acceptance.
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [DW-1:0]   rsum_q, rsum_next;
  logic            row_end, frame_end;

  assign rsum_next = rsum_q + s_axis_tdata_i;
  assign row_end   = ((CmpW'(col_q) + CmpW'(1)) >= cols_eff);
  assign frame_end = row_end && (((RowW+1)'(row_q) + (RowW+1)'(1)) >= rows_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rsum_q <= '0;
    end else if (s_acc) begin
      if (row_end) begin
        col_q  <= '0;
        rsum_q <= '0;
        row_q  <= frame_end ? '0 : row_q + RowW'(1);
      end else begin
        col_q  <= col_q + ColW'(1);
        rsum_q <= rsum_next;
      end
    end
  end

  // Read stage payload.
  logic [ColW-1:0] s1_col_q;
  logic [DW-1:0]   s1_rsum_q;
  logic            s1_first_q, s1_row_end_q, s1_frame_end_q;
  logic            s1_fwd_q;
  logic [DW-1:0]   s1_fwd_data_q;
  logic [DW-1:0]   s1_above, s1_sum;
  logic            mem_wr;

  // Line memory of the previous row's sums.
  logic [DW-1:0] line_mem_q [MAX_COLUMNS];
  logic [DW-1:0] rdata_q;

  assign mem_wr   = s1_valid_q && adv;
  assign s1_above = s1_first_q ? '0 : (s1_fwd_q ? s1_fwd_data_q : rdata_q);
  assign s1_sum   = s1_rsum_q + s1_above;

  always_ff @(posedge clk_i) begin
    if (mem_wr) line_mem_q[s1_col_q] <= s1_sum;
    if (s_acc)  rdata_q <= line_mem_q[col_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // A write to the entry being read at the same edge would be missed by the
  // memory read, so its data is captured here instead.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_col_q       <= col_q;
      s1_rsum_q      <= rsum_next;
      s1_first_q     <= (row_q == '0);
      s1_row_end_q   <= row_end;
      s1_frame_end_q <= frame_end;
      s1_fwd_q       <= mem_wr && (s1_col_q == col_q);
      s1_fwd_data_q  <= s1_sum;
    end
  end

  // Output register.
  logic [DW-1:0] s2_sum_q;
  logic          s2_row_end_q, s2_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      s2_sum_q       <= s1_sum;
      s2_row_end_q   <= s1_row_end_q;
      s2_frame_end_q <= s1_frame_end_q;
    end
  end

  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tdata_o  = s2_sum_q;
  assign m_axis_tuser_o  = s2_row_end_q;
  assign m_axis_tlast_o  = s2_frame_end_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  a_frame_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("frame end without row end");

  a_ready_when_read_stage_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty read stage");

  a_column_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !row_end |=> col_q == $past(col_q) + ColW'(1))
    else $error("column index did not advance");

  a_row_start_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && row_end |=> col_q == '0 && rsum_q == '0)
    else $error("row end did not restart the row");

endmodule

`default_nettype wire
